// File: rtl/lpht_pkg.sv
package lpht_pkg;

   // field widths
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned HKEY_W = 31;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned SIZE_W = 9;
   localparam int unsigned SLOT_W = 8;
   localparam int unsigned OCC_W  = 9;

   // table_size after reset
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 9'd256;

   // remainder unit: dividend padded to whole digits, one digit per step
   localparam int unsigned MOD_DIGIT_BITS = 4;
   localparam int unsigned MOD_DIVIDEND_W = 32;
   localparam int unsigned MOD_STEPS      = MOD_DIVIDEND_W / MOD_DIGIT_BITS;
   localparam int unsigned MOD_STEP_W     = $clog2(MOD_STEPS);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_PROBE,
      ST_RESP
   } state_type;

   typedef struct packed {
      func_type            func;
      logic [KEY_W-1:0]    key;
      logic [DATA_W-1:0]   data;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_W-1:0]    out_key;
      logic [DATA_W-1:0]   out_data;
      logic [SLOT_W-1:0]   out_slot;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

// File: rtl/lpht_mod_unit.sv
module lpht_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpht_pkg::HKEY_W-1:0] dividend,
   input  logic [lpht_pkg::SIZE_W-1:0] divisor,
   output logic                        done,
   output logic [lpht_pkg::SIZE_W-1:0] remainder
);
   import lpht_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MOD_STEP_W-1:0]     step_ff, step_in;
   logic [MOD_DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [SIZE_W-1:0]         rem_ff, rem_in;
   logic [SIZE_W-1:0]         div_ff, div_in;
   logic [SIZE_W-1:0]         rem_step;

   // one digit of restoring remainder per cycle
   always_comb begin
      logic [SIZE_W:0]   trial;
      logic [SIZE_W-1:0] part;
      part = rem_ff;
      for (int i = 0; i < MOD_DIGIT_BITS; i++) begin
         trial = {part, shift_ff[MOD_DIVIDEND_W-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         part = trial[SIZE_W-1:0];
      end
      rem_step = part;
   end

   // step control
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = MOD_DIVIDEND_W'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << MOD_DIGIT_BITS;
         step_in  = step_ff + 1'b1;
         if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/lpht_slot_store.sv
module lpht_slot_store #(
   parameter int unsigned DEPTH         = 256,
   parameter int unsigned IDX_W         = 8,
   parameter int unsigned PAYLOAD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic                        wr_valid,
   input  logic [lpht_pkg::HKEY_W-1:0] wr_key,
   input  logic [PAYLOAD_WIDTH-1:0]    wr_payload,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic                        rd_valid,
   output logic [lpht_pkg::HKEY_W-1:0] rd_key,
   output logic [PAYLOAD_WIDTH-1:0]    rd_payload
);
   import lpht_pkg::*;

   localparam int unsigned WORD_W = 1 + HKEY_W + PAYLOAD_WIDTH;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_valid, wr_key, wr_payload};
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_valid   = rd_word_ff[WORD_W-1];
   assign rd_key     = rd_word_ff[WORD_W-2:PAYLOAD_WIDTH];
   assign rd_payload = rd_word_ff[PAYLOAD_WIDTH-1:0];

endmodule

// File: rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing.
// req channel: one request (insert, search, delete, clear) per transfer; req_ready is
// high only while the table waits for work. rsp channel: exactly one result per request,
// held in an output register until rsp_ready takes it. csr channel: writes table_size,
// always ready, to be used only between requests.
// Steps per request: take it, run the remainder unit (4 key bits per cycle) for the home
// slot, then walk one slot per cycle through the slot memory read port, with the
// registered read between each slot read and its compare. A search or delete stops at
// the slot that hits; a miss, or an insert of a new key, walks the whole live size.
// An insert into a full table raises rsp_valid in the cycle after its transfer, skipping the walk.
// A clear sweeps the memory valid bits one slot per cycle over min(TABLE_DEPTH, 511) slots.
// Next request is taken in the cycle after the result transfer; a stalled receiver keeps
// the result and the table waiting.
// Reset (synchronous) runs the same sweep over min(TABLE_DEPTH, 511) slots, with no
// result and req_ready low; table_size returns to 256 at once.
module linear_probe_hash_table #(
   parameter int unsigned TABLE_DEPTH   = 256,
   parameter int unsigned PAYLOAD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lpht_pkg::req_type           req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lpht_pkg::rsp_type           rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lpht_pkg::SIZE_W-1:0] csr_data
);
   import lpht_pkg::*;

   // only the first 511 slots can ever be reached by a 9-bit table_size
   localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
   localparam int unsigned IDX_W     = $clog2(MEM_DEPTH);
   localparam int unsigned CNT_W     = $clog2(MEM_DEPTH + 1);
   localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MEM_DEPTH - 1);

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  table_size_ff, table_size_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic               clr_resp_ff, clr_resp_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic [SIZE_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [SIZE_W-1:0]  chk_cnt_ff, chk_cnt_in;
   logic               pend_ff, pend_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   logic [SIZE_W-1:0]        live_size;
   logic [SIZE_W-1:0]        size_m1;
   logic                     full_now;
   logic                     mod_start;
   logic                     mod_done;
   logic [SIZE_W-1:0]        mod_rem;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_valid;
   logic [HKEY_W-1:0]        rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_payload;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     wr_valid;
   logic [HKEY_W-1:0]        wr_key;
   logic [PAYLOAD_WIDTH-1:0] wr_payload;
   logic                     hit;
   logic                     probe_done;
   logic                     free_any;
   logic [IDX_W-1:0]         free_sel;
   logic [15:0]              chk_wide;
   logic [15:0]              free_wide;
   logic [63:0]              pay_wide;

   lpht_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_item.key[HKEY_W-1:0]),
      .divisor   (live_size),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lpht_slot_store #(
      .DEPTH         (MEM_DEPTH),
      .IDX_W         (IDX_W),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_valid   (wr_valid),
      .wr_key     (wr_key),
      .wr_payload (wr_payload),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_valid   (rd_valid),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   // effective size: zero acts as one, clipped to the memory depth
   always_comb begin
      if (table_size_ff == '0) begin
         live_size = SIZE_W'(1);
      end else if ({1'b0, table_size_ff} > (SIZE_W + 1)'(MEM_DEPTH)) begin
         live_size = SIZE_W'(MEM_DEPTH);
      end else begin
         live_size = table_size_ff;
      end
   end

   assign full_now = (SIZE_W + 1)'(count_ff) >= (SIZE_W + 1)'(live_size);
   assign size_m1  = size_ff - 1'b1;

   // probe compare on the slot read last cycle
   assign hit        = pend_ff && rd_valid && (rd_key == req_ff.key[HKEY_W-1:0]);
   assign probe_done = pend_ff && (hit || (chk_cnt_ff == size_m1));
   assign free_any   = free_found_ff || !rd_valid;
   assign free_sel   = free_found_ff ? free_idx_ff : chk_idx_ff;
   assign chk_wide   = 16'(chk_idx_ff);
   assign free_wide  = 16'(free_sel);
   assign pay_wide   = 64'(rd_payload);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.func == FUNC_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_item.func == FUNC_INSERT && full_now) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      size_in       = size_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      clr_resp_in   = clr_resp_ff;
      issue_idx_in  = issue_idx_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_cnt_in    = chk_cnt_ff;
      pend_in       = pend_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      mod_start     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = issue_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_valid      = 1'b0;
      wr_key        = req_ff.key[HKEY_W-1:0];
      wr_payload    = PAYLOAD_WIDTH'(req_ff.data);
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;

      unique case (state_ff)
         // clear valid bits one slot per cycle
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_valid = 1'b0;
            sweep_in = sweep_ff + 1'b1;
         end
         // take a request
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in           = req_item;
               size_in          = live_size;
               rsp_in           = '0;
               rsp_in.status    = STATUS_OK;
               rsp_in.occupancy = OCC_W'(count_ff);
               if (req_item.func == FUNC_CLEAR) begin
                  count_in    = '0;
                  sweep_in    = '0;
                  clr_resp_in = 1'b1;
                  rsp_in.occupancy = '0;
               end else if (req_item.func == FUNC_INSERT && full_now) begin
                  rsp_in.status  = STATUS_FULL;
                  rsp_in.out_key = req_item.key;
               end else begin
                  mod_start = 1'b1;
               end
            end
         end
         // home slot ready: arm the probe walk
         ST_MOD: begin
            if (mod_done) begin
               issue_idx_in  = mod_rem[IDX_W-1:0];
               issue_cnt_in  = '0;
               chk_cnt_in    = '0;
               pend_in       = 1'b0;
               free_found_in = 1'b0;
            end
         end
         // issue one slot read per cycle, compare the one read last cycle
         ST_PROBE: begin
            if (issue_cnt_ff != size_ff) begin
               rd_en        = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               chk_idx_in   = issue_idx_ff;
               pend_in      = 1'b1;
               if (SIZE_W'(issue_idx_ff) == size_m1) begin
                  issue_idx_in = '0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (!rd_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end
            // finish the request
            if (probe_done) begin
               rsp_in        = '0;
               rsp_in.status = STATUS_OK;
               unique case (req_ff.func)
                  FUNC_INSERT: begin
                     rsp_in.out_key = req_ff.key;
                     if (hit) begin
                        rsp_in.status   = STATUS_DUPLICATE;
                        rsp_in.out_slot = chk_wide[SLOT_W-1:0];
                     end else if (free_any) begin
                        wr_en           = 1'b1;
                        wr_addr         = free_sel;
                        wr_valid        = 1'b1;
                        count_in        = count_ff + 1'b1;
                        rsp_in.out_slot = free_wide[SLOT_W-1:0];
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  FUNC_SEARCH: begin
                     if (hit) begin
                        rsp_in.out_key  = KEY_W'(rd_key);
                        rsp_in.out_data = pay_wide[DATA_W-1:0];
                        rsp_in.out_slot = chk_wide[SLOT_W-1:0];
                     end else begin
                        rsp_in.status = STATUS_NOT_FOUND;
                     end
                  end
                  FUNC_DELETE: begin
                     if (hit) begin
                        wr_en    = 1'b1;
                        wr_addr  = chk_idx_ff;
                        wr_valid = 1'b0;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                        rsp_in.out_slot = chk_wide[SLOT_W-1:0];
                     end else begin
                        rsp_in.status = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_OK;
                  end
               endcase
               rsp_in.occupancy = OCC_W'(count_in);
            end
         end
         // hold the result until transfer
         ST_RESP: begin
            rsp_valid   = 1'b1;
            clr_resp_in = 1'b0;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   // configuration register
   assign csr_ready     = 1'b1;
   assign table_size_in = csr_valid ? csr_data : table_size_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         table_size_ff <= TABLE_SIZE_RESET;
         count_ff      <= '0;
         sweep_ff      <= '0;
         clr_resp_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         count_ff      <= count_in;
         sweep_ff      <= sweep_in;
         clr_resp_ff   <= clr_resp_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      size_ff       <= size_in;
      issue_idx_ff  <= issue_idx_in;
      issue_cnt_ff  <= issue_cnt_in;
      chk_idx_ff    <= chk_idx_in;
      chk_cnt_ff    <= chk_cnt_in;
      pend_ff       <= pend_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   assign rsp_item = rsp_ff;

endmodule

// File: test/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   localparam int unsigned DEPTH          = 256;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 300;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned POOL_SIZE      = 24;
   localparam int unsigned PHASES         = 12;

   // one line of the directed stimulus: either a table_size write or a request
   typedef struct {
      bit                is_cfg;
      logic [SIZE_W-1:0] cfg;
      req_type           req;
      bit                pinned;
      rsp_type           pin;
   } script_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_item;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_item;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data;

   // shadow copy of the table
   logic [SIZE_W-1:0] size_reg;
   bit                slot_used [DEPTH];
   logic [HKEY_W-1:0] slot_key_m [DEPTH];
   logic [DATA_W-1:0] slot_data_m [DEPTH];
   int unsigned       entry_total;
   rsp_type           pending_results [$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned quiet_cycles;
   int          error_count;
   int          result_count;

   linear_probe_hash_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // linear probe from the home slot, looking for the key or for a free slot
   function automatic bit probe(logic [HKEY_W-1:0] k, int unsigned sz, bit want_free,
                                output int unsigned at);
      int unsigned idx;
      idx = k % sz;
      at = 0;
      for (int unsigned n = 0; n < sz; n++) begin
         if (want_free ? !slot_used[idx] : (slot_used[idx] && slot_key_m[idx] == k)) begin
            at = idx;
            return 1'b1;
         end
         idx = (idx + 1 == sz) ? 0 : idx + 1;
      end
      return 1'b0;
   endfunction

   // apply one request to the shadow table and return the result it gives
   function automatic rsp_type apply_request(req_type r);
      rsp_type           res;
      logic [HKEY_W-1:0] k;
      int unsigned       sz;
      int unsigned       at;
      k = r.key[HKEY_W-1:0];
      sz = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
      res = '0;
      case (r.func)
         FUNC_INSERT: begin
            res.out_key = r.key;
            if (entry_total >= sz) begin
               res.status = STATUS_FULL;
            end else if (probe(k, sz, 1'b0, at)) begin
               res.status = STATUS_DUPLICATE;
               res.out_slot = at[SLOT_W-1:0];
            end else if (probe(k, sz, 1'b1, at)) begin
               slot_used[at] = 1'b1;
               slot_key_m[at] = k;
               slot_data_m[at] = r.data;
               entry_total++;
               res.out_slot = at[SLOT_W-1:0];
            end else begin
               res.status = STATUS_FULL;
            end
         end
         FUNC_SEARCH: begin
            if (probe(k, sz, 1'b0, at)) begin
               res.out_key = {1'b0, slot_key_m[at]};
               res.out_data = slot_data_m[at];
               res.out_slot = at[SLOT_W-1:0];
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         FUNC_DELETE: begin
            if (probe(k, sz, 1'b0, at)) begin
               slot_used[at] = 1'b0;
               if (entry_total > 0) entry_total--;
               res.out_slot = at[SLOT_W-1:0];
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            entry_total = 0;
         end
      endcase
      res.occupancy = entry_total[OCC_W-1:0];
      return res;
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic [KEY_W-1:0] k,
                                        logic [DATA_W-1:0] d, logic [SLOT_W-1:0] s,
                                        logic [OCC_W-1:0] occ);
      rsp_type res;
      res.status = st;
      res.out_key = k;
      res.out_data = d;
      res.out_slot = s;
      res.occupancy = occ;
      return res;
   endfunction

   function automatic script_row_type req_row(func_type f, logic [KEY_W-1:0] k,
                                              logic [DATA_W-1:0] d, bit pinned,
                                              rsp_type pin);
      script_row_type row;
      row.is_cfg = 1'b0;
      row.cfg = '0;
      row.req.func = f;
      row.req.key = k;
      row.req.data = d;
      row.pinned = pinned;
      row.pin = pin;
      return row;
   endfunction

   function automatic script_row_type cfg_row(logic [SIZE_W-1:0] v);
      script_row_type row;
      row.is_cfg = 1'b1;
      row.cfg = v;
      row.req = '0;
      row.pinned = 1'b0;
      row.pin = '0;
      return row;
   endfunction

   // present one request, wait for its transfer, then queue the result it should give
   task automatic send_request(req_type r, bit pinned, rsp_type pin);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(r);
      pending_results.push_back(pinned ? pin : predicted);
   endtask

   // table_size write, only once the table has gone idle
   task automatic write_table_size(logic [SIZE_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      size_reg = v;
      csr_valid <= 1'b0;
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display({"result %0d with nothing pending: ",
                         "status %0d key %h data %h slot %0d occ %0d"},
                        result_count, rsp_item.status, rsp_item.out_key, rsp_item.out_data,
                        rsp_item.out_slot, rsp_item.occupancy);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status || rsp_item.out_key !== want.out_key ||
                rsp_item.out_data !== want.out_data || rsp_item.out_slot !== want.out_slot ||
                rsp_item.occupancy !== want.occupancy) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("result %0d mismatch", result_count);
                  $display("  expected status %0d key %h data %h slot %0d occ %0d",
                           want.status, want.out_key, want.out_data, want.out_slot,
                           want.occupancy);
                  $display("  actual   status %0d key %h data %h slot %0d occ %0d",
                           rsp_item.status, rsp_item.out_key, rsp_item.out_data,
                           rsp_item.out_slot, rsp_item.occupancy);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      script_row_type    directed [$];
      logic [KEY_W-1:0]  key_pool [POOL_SIZE];
      logic [SIZE_W-1:0] phase_sizes [PHASES];
      req_type           r;
      int unsigned       pick;
      int unsigned       items;

      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      size_reg = TABLE_SIZE_RESET;
      entry_total = 0;
      phase_sizes = '{3, 0, 16, 1, 7, 256, 2, 40, 511, 5, 11, 300};

      // empty table at reset size
      directed.push_back(req_row(FUNC_SEARCH, 32'h0, 32'h0, 1'b1,
                                 make_rsp(STATUS_NOT_FOUND, 0, 0, 0, 0)));
      directed.push_back(req_row(FUNC_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                 make_rsp(STATUS_NOT_FOUND, 0, 0, 0, 0)));
      directed.push_back(req_row(FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                 make_rsp(STATUS_OK, 0, 0, 0, 1)));
      // bit 31 is not part of the key, so this is a duplicate
      directed.push_back(req_row(FUNC_INSERT, 32'h8000_0000, 32'h0, 1'b1,
                                 make_rsp(STATUS_DUPLICATE, 32'h8000_0000, 0, 0, 1)));
      directed.push_back(req_row(FUNC_SEARCH, 32'h8000_0000, 32'h0, 1'b1,
                                 make_rsp(STATUS_OK, 0, 32'hFFFF_FFFF, 0, 1)));
      // collisions and wrap from the last slot
      directed.push_back(req_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0));
      directed.push_back(req_row(FUNC_INSERT, 32'd256, 32'h5555_AAAA, 1'b0, '0));
      directed.push_back(req_row(FUNC_INSERT, 32'd511, 32'hAAAA_5555, 1'b0, '0));
      directed.push_back(req_row(FUNC_SEARCH, 32'd511, 32'h0, 1'b0, '0));
      directed.push_back(req_row(FUNC_DELETE, 32'd256, 32'h0, 1'b0, '0));
      // entry behind a freed slot stays reachable
      directed.push_back(req_row(FUNC_SEARCH, 32'd511, 32'h0, 1'b0, '0));
      directed.push_back(req_row(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                 make_rsp(STATUS_OK, 0, 0, 0, 0)));
      directed.push_back(req_row(FUNC_SEARCH, 32'd511, 32'h0, 1'b1,
                                 make_rsp(STATUS_NOT_FOUND, 0, 0, 0, 0)));
      // size zero acts as one slot
      directed.push_back(cfg_row(9'd0));
      directed.push_back(req_row(FUNC_INSERT, 32'd5, 32'hA5A5_A5A5, 1'b1,
                                 make_rsp(STATUS_OK, 32'd5, 0, 0, 1)));
      directed.push_back(req_row(FUNC_INSERT, 32'd6, 32'h0, 1'b1,
                                 make_rsp(STATUS_FULL, 32'd6, 0, 0, 1)));
      directed.push_back(req_row(FUNC_INSERT, 32'd5, 32'h0, 1'b1,
                                 make_rsp(STATUS_FULL, 32'd5, 0, 0, 1)));
      // oversized value acts as the full depth
      directed.push_back(cfg_row(9'd511));
      directed.push_back(req_row(FUNC_SEARCH, 32'd5, 32'h0, 1'b0, '0));
      directed.push_back(req_row(FUNC_INSERT, 32'h7FFF_FFFF, 32'hC3C3_3C3C, 1'b0, '0));
      // shrink with an entry left beyond the new size
      directed.push_back(cfg_row(9'd2));
      directed.push_back(req_row(FUNC_INSERT, 32'd3, 32'h0F0F_F0F0, 1'b0, '0));
      directed.push_back(req_row(FUNC_SEARCH, 32'h7FFF_FFFF, 32'h0, 1'b0, '0));
      directed.push_back(req_row(FUNC_DELETE, 32'd5, 32'h0, 1'b0, '0));
      directed.push_back(req_row(FUNC_INSERT, 32'd4, 32'h8765_4321, 1'b0, '0));
      directed.push_back(req_row(FUNC_CLEAR, 32'h0, 32'h0, 1'b1,
                                 make_rsp(STATUS_OK, 0, 0, 0, 0)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // wait out the clearing sweep after reset
      while (req_ready !== 1'b1) @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg) write_table_size(directed[i].cfg);
         else send_request(directed[i].req, directed[i].pinned, directed[i].pin);
      end

      // random phases, small key pool per phase so hits, duplicates and full tables occur
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         write_table_size(phase_sizes[p]);
         foreach (key_pool[i]) key_pool[i] = $urandom;
         items = (phase_sizes[p] > 64) ? 60 : 140;
         repeat (items) begin
            pick = $urandom_range(99);
            r.func = (pick < 42) ? FUNC_INSERT :
                     (pick < 72) ? FUNC_SEARCH :
                     (pick < 95) ? FUNC_DELETE : FUNC_CLEAR;
            r.key = ($urandom_range(9) == 0) ? $urandom :
                    key_pool[$urandom_range(POOL_SIZE - 1)] ^
                    (($urandom_range(3) == 0) ? 32'h8000_0000 : 32'h0);
            r.data = $urandom;
            send_request(r, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/lpht_pkg.sv
rtl/lpht_mod_unit.sv
rtl/lpht_slot_store.sv
rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_tb.sv
